/* rtl/mi3_pkg.sv */
package mi3_pkg;

  // Default element format: Q16.16
  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Configuration space
  localparam int THR_WIDTH   = 16;
  localparam int PDATA_WIDTH = 32;
  localparam int PADDR_WIDTH = 2;

  typedef enum logic [PADDR_WIDTH-1:0] {
    REG_SINGULAR_THRESHOLD = 2'd0
  } reg_addr_t;

  localparam logic [THR_WIDTH-1:0] THR_RESET = 16'd3;

  // Cofactor operand indexes {p, q, r, s}: c = m[p]*m[q] - m[r]*m[s]
  typedef logic [3:0] idx_t;
  localparam idx_t COF_IDX [9][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd7, 4'd2, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd4, 4'd2},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd6, 4'd2},
    '{4'd3, 4'd2, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd6, 4'd4},
    '{4'd6, 4'd1, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  // Cofactors of the first row, used for the determinant
  localparam idx_t ROW0_COF [3] = '{4'd0, 4'd3, 4'd6};

endpackage

/* rtl/mi3_if.sv */
interface mi3_in_if import mi3_pkg::*; #(
  parameter int W = ELEM_WIDTH_DEF
);
  logic valid;
  logic ready;
  logic signed [W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  input ready);
  modport sink (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                output ready);
endinterface

interface mi3_out_if import mi3_pkg::*; #(
  parameter int W = ELEM_WIDTH_DEF
);
  logic valid;
  logic ready;
  logic invertible;
  logic signed [W-1:0] b00, b01, b02, b10, b11, b12, b20, b21, b22;

  modport source (output valid, invertible, b00, b01, b02, b10, b11, b12, b20, b21, b22,
                  input ready);
  modport sink (input valid, invertible, b00, b01, b02, b10, b11, b12, b20, b21, b22,
                output ready);
endinterface

/* rtl/matrix3x3_inverse_unit.sv */
// Channel   Dir   Payload                              Handshake
// mat_in    in    a00..a22, signed ELEM_WIDTH each     valid/ready
// mat_out   out   invertible, b00..b22                 valid/ready
// apb       in    singular_threshold at byte addr 0    psel/penable, pready=1
//
// One matrix enters per cycle while mat_in.ready is high.
// The depth is set by the restoring divider: one quotient bit per stage,
// nine lanes side by side, after five stages of cofactor and determinant work.
// Reset clears all stage valid bits and sets the threshold to 3.
// A stall on mat_out holds full stages; empty stages keep filling behind it.
module matrix3x3_inverse_unit import mi3_pkg::*; #(
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  mi3_in_if.sink                 mat_in,
  mi3_out_if.source              mat_out,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_WIDTH-1:0] paddr,
  input  logic [PDATA_WIDTH-1:0] pwdata,
  output logic [PDATA_WIDTH-1:0] prdata,
  output logic                   pready
);

  localparam int E  = ELEM_WIDTH;
  localparam int CW = 2*E + 1;                 // cofactor width
  localparam int DW = 3*E + 2;                 // determinant width
  localparam int NW = CW + 2*FRAC_BITS;        // shifted numerator width
  localparam int RW = (NW > DW + E) ? NW + 1 : DW + E + 1;
  localparam int NS = E + 6;                   // pipeline stages
  localparam int DV0 = 5;                      // first divider stage
  localparam int OST = NS - 1;                 // output stage

  typedef struct packed {
    logic [8:0][RW-1:0] rem;
    logic [8:0][E-1:0]  q;
    logic [8:0]         sat;
    logic [8:0]         neg;
    logic [DW-1:0]      dmag;
    logic               sing;
  } dv_t;

  logic [THR_WIDTH-1:0] thr;
  logic [NS-1:0]        vld;
  logic [NS-1:0]        en;

  logic signed [E-1:0]    m_in [9];
  logic signed [2*E-1:0]  s1_p0 [9];
  logic signed [2*E-1:0]  s1_p1 [9];
  logic signed [E-1:0]    s1_r0 [3];
  logic signed [CW-1:0]   s2_c  [9];
  logic signed [E-1:0]    s2_r0 [3];
  logic signed [CW-1:0]   s3_pl [3];
  logic signed [CW-1:0]   s3_ph [3];
  logic signed [CW-1:0]   s3_c  [9];
  logic signed [DW-1:0]   s4_det;
  logic signed [CW-1:0]   s4_c  [9];
  dv_t                    dv    [E+1];
  dv_t                    dv_nx [E+1];
  logic                   o_inv;
  logic [E-1:0]           o_b   [9];

  logic signed [DW-1:0]   det_sum;
  logic signed [DW-1:0]   t_hi, t_lo;
  logic [DW-1:0]          dabs;
  logic [CW-1:0]          cabs;
  logic [RW-1:0]          thr_sh;
  logic [E-1:0]           lim;
  logic [E-1:0]           b_nx [9];

  // Configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (psel && penable && pwrite && paddr == REG_SINGULAR_THRESHOLD) begin
      thr <= pwdata[THR_WIDTH-1:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == REG_SINGULAR_THRESHOLD) prdata = {{(PDATA_WIDTH-THR_WIDTH){1'b0}}, thr};
  end

  // Stage enables: a stage loads when empty or when the next one moves
  always_comb begin
    en[NS-1] = !vld[NS-1] || mat_out.ready;
    for (int k = NS-2; k >= 0; k--) en[k] = !vld[k] || en[k+1];
  end
  assign mat_in.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= mat_in.valid;
      for (int k = 1; k < NS; k++) if (en[k]) vld[k] <= vld[k-1];
    end
  end

  assign m_in = '{mat_in.a00, mat_in.a01, mat_in.a02, mat_in.a10, mat_in.a11,
                  mat_in.a12, mat_in.a20, mat_in.a21, mat_in.a22};

  // Stage 1: the eighteen cofactor products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 9; i++) begin
        s1_p0[i] <= m_in[COF_IDX[i][0]] * m_in[COF_IDX[i][1]];
        s1_p1[i] <= m_in[COF_IDX[i][2]] * m_in[COF_IDX[i][3]];
      end
      for (int j = 0; j < 3; j++) s1_r0[j] <= m_in[j];
    end
  end

  // Stage 2: cofactor differences
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 9; i++) s2_c[i] <= CW'(s1_p0[i]) - CW'(s1_p1[i]);
      s2_r0 <= s1_r0;
    end
  end

  // Stage 3: first-row products split into low and high cofactor halves
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int j = 0; j < 3; j++) begin
        s3_pl[j] <= s2_r0[j] * $signed({1'b0, s2_c[ROW0_COF[j]][E-1:0]});
        s3_ph[j] <= s2_r0[j] * $signed(s2_c[ROW0_COF[j]][CW-1:E]);
      end
      s3_c <= s2_c;
    end
  end

  // Stage 4: determinant
  always_comb begin
    det_sum = '0;
    t_hi = '0;
    t_lo = '0;
    for (int j = 0; j < 3; j++) begin
      t_hi = DW'(s3_ph[j]);
      t_lo = DW'(s3_pl[j]);
      det_sum = det_sum + (t_hi <<< E) + t_lo;
    end
  end
  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_det <= det_sum;
      s4_c   <= s3_c;
    end
  end

  // Stage 5: magnitudes, signs, singular test, saturation check
  assign thr_sh = RW'(thr) << (2*FRAC_BITS);
  always_comb begin
    dv_nx[0] = '0;
    dabs = s4_det[DW-1] ? DW'(-s4_det) : DW'(s4_det);
    cabs = '0;
    dv_nx[0].dmag = dabs;
    dv_nx[0].sing = (dabs == '0) || (RW'(dabs) < thr_sh);
    for (int i = 0; i < 9; i++) begin
      cabs = s4_c[i][CW-1] ? CW'(-s4_c[i]) : CW'(s4_c[i]);
      dv_nx[0].neg[i] = s4_c[i][CW-1] ^ s4_det[DW-1];
      dv_nx[0].rem[i] = RW'(cabs) << (2*FRAC_BITS);
      dv_nx[0].sat[i] = dv_nx[0].rem[i] >= (RW'(dabs) << E);
    end
  end
  always_ff @(posedge clk) begin
    if (en[4]) dv[0] <= dv_nx[0];
  end

  // Divider stages: one quotient bit per stage in each lane
  for (genvar k = 0; k < E; k++) begin : g_div
    localparam int B = E - 1 - k;
    logic [RW-1:0] dsh;
    assign dsh = RW'(dv[k].dmag) << B;
    always_comb begin
      dv_nx[k+1] = dv[k];
      for (int i = 0; i < 9; i++) begin
        if (!dv[k].sat[i] && dv[k].rem[i] >= dsh) begin
          dv_nx[k+1].rem[i]  = dv[k].rem[i] - dsh;
          dv_nx[k+1].q[i][B] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en[DV0+k]) dv[k+1] <= dv_nx[k+1];
    end
  end

  // Output stage: sign, saturate, zero on singular
  assign lim = {1'b1, {(E-1){1'b0}}};
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      if (dv[E].sing) begin
        b_nx[i] = '0;
      end else if (dv[E].neg[i]) begin
        b_nx[i] = (dv[E].sat[i] || dv[E].q[i] > lim) ? lim : E'(0) - dv[E].q[i];
      end else begin
        b_nx[i] = (dv[E].sat[i] || dv[E].q[i] > lim - 1'b1) ? lim - 1'b1 : dv[E].q[i];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en[OST]) begin
      o_inv <= !dv[E].sing;
      o_b   <= b_nx;
    end
  end

  assign mat_out.valid      = vld[OST];
  assign mat_out.invertible = o_inv;
  assign mat_out.b00 = o_b[0];
  assign mat_out.b01 = o_b[1];
  assign mat_out.b02 = o_b[2];
  assign mat_out.b10 = o_b[3];
  assign mat_out.b11 = o_b[4];
  assign mat_out.b12 = o_b[5];
  assign mat_out.b20 = o_b[6];
  assign mat_out.b21 = o_b[7];
  assign mat_out.b22 = o_b[8];

  // A singular result carries all-zero entries
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    vld[OST] && !o_inv |-> o_b[0] == '0 && o_b[4] == '0 && o_b[8] == '0)
    else $error("singular result with nonzero entries");

  // A result appears only behind a filled last divider stage
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(vld[OST]) |-> $past(vld[OST-1]))
    else $error("output valid without a preceding item");

  // A zero determinant is always flagged singular
  a_zero_det: assert property (@(posedge clk) disable iff (rst)
    vld[DV0-1] && dv[0].dmag == '0 |-> dv[0].sing)
    else $error("zero determinant not singular");

endmodule
